// ===== rtl/bba_pkg.sv =====
`timescale 1ns / 1ps
package bba_pkg;

   localparam int LEVELS     = 11;
   localparam int TOP        = LEVELS - 1;
   localparam int HEAP_UNITS = 1 << TOP;
   localparam int IDX_W      = 10;
   localparam int LVL_W      = 4;
   localparam int UNITS_W    = 11;
   localparam int CNT_W      = 11;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_APOP,
      S_POP_HEAD,
      S_SPLIT_DEC,
      S_SPLIT_PUSH,
      S_FCHK,
      S_BPOP,
      S_WALK,
      S_UNLINK,
      S_DONE
   } state_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_ALLOC_SEL,
      CMD_ALLOC_POP,
      CMD_POP_HEAD,
      CMD_SPLIT_DEC,
      CMD_SPLIT_PUSH,
      CMD_ALLOC_DONE,
      CMD_FAIL,
      CMD_PUSH,
      CMD_BUDDY_READ,
      CMD_BPOP,
      CMD_WALK_START,
      CMD_WALK_STEP,
      CMD_UNLINK_READ,
      CMD_UNLINK
   } cmd_type;

   typedef struct packed {
      logic is_free;
      logic alloc_fail;
      logic lv_gt_need;
      logic at_top;
      logic head_vld_lv;
      logic head_is_buddy;
      logic link_vld;
      logic nxt_is_buddy;
      logic walk_limit;
   } status_type;

endpackage

// ===== rtl/bba_ctrl.sv =====
`timescale 1ns / 1ps
module bba_ctrl
   import bba_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_fire,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd,
   output logic       req_tready,
   output logic       rsp_tvalid
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = CMD_NONE;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_fire) begin
               cmd      = CMD_LOAD;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (status.is_free) begin
               state_in = S_FCHK;
            end else if (status.alloc_fail) begin
               cmd      = CMD_FAIL;
               state_in = S_DONE;
            end else begin
               cmd      = CMD_ALLOC_SEL;
               state_in = S_APOP;
            end
         end
         S_APOP: begin
            cmd      = CMD_ALLOC_POP;
            state_in = S_POP_HEAD;
         end
         S_POP_HEAD: begin
            cmd      = CMD_POP_HEAD;
            state_in = S_SPLIT_DEC;
         end
         S_SPLIT_DEC: begin
            if (status.lv_gt_need) begin
               cmd      = CMD_SPLIT_DEC;
               state_in = S_SPLIT_PUSH;
            end else begin
               cmd      = CMD_ALLOC_DONE;
               state_in = S_DONE;
            end
         end
         S_SPLIT_PUSH: begin
            cmd      = CMD_SPLIT_PUSH;
            state_in = S_SPLIT_DEC;
         end
         S_FCHK: begin
            if (status.at_top || !status.head_vld_lv) begin
               cmd      = CMD_PUSH;
               state_in = S_DONE;
            end else if (status.head_is_buddy) begin
               cmd      = CMD_BUDDY_READ;
               state_in = S_BPOP;
            end else begin
               cmd      = CMD_WALK_START;
               state_in = S_WALK;
            end
         end
         S_BPOP: begin
            cmd      = CMD_BPOP;
            state_in = S_FCHK;
         end
         S_WALK: begin
            // end of list or visit budget spent: buddy not free
            if (status.walk_limit || !status.link_vld) begin
               cmd      = CMD_PUSH;
               state_in = S_DONE;
            end else if (status.nxt_is_buddy) begin
               cmd      = CMD_UNLINK_READ;
               state_in = S_UNLINK;
            end else begin
               cmd = CMD_WALK_STEP;
            end
         end
         S_UNLINK: begin
            cmd      = CMD_UNLINK;
            state_in = S_FCHK;
         end
         S_DONE: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/bba_datapath.sv =====
`timescale 1ns / 1ps
module bba_datapath
   import bba_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   input  logic                req_opcode,
   input  logic [UNITS_W-1:0]  req_units,
   input  logic [IDX_W-1:0]    req_index,
   input  logic [LVL_W-1:0]    req_level,
   output status_type          status,
   output logic                rsp_ok,
   output logic [IDX_W-1:0]    rsp_index,
   output logic [LVL_W-1:0]    rsp_level
);

   logic [IDX_W:0]     link_mem [HEAP_UNITS];

   logic [IDX_W-1:0]   head_idx_ff [LEVELS];
   logic [LEVELS-1:0]  head_vld_ff;
   logic               opc_ff;
   logic [UNITS_W-1:0] units_ff;
   logic [IDX_W-1:0]   addr_ff;
   logic [LVL_W-1:0]   lv_ff;
   logic [LVL_W-1:0]   need_ff;
   logic [IDX_W-1:0]   cur_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [IDX_W:0]     rdata_ff;
   logic               ok_ff;
   logic [IDX_W-1:0]   res_idx_ff;
   logic [LVL_W-1:0]   res_lv_ff;

   logic [LVL_W-1:0]   need;
   logic [LVL_W-1:0]   first;
   logic               found;
   logic [IDX_W-1:0]   bit_lv;
   logic [IDX_W-1:0]   buddy;
   logic [IDX_W-1:0]   merged;
   logic [IDX_W-1:0]   nxt;
   logic [IDX_W-1:0]   half_blk;
   logic [IDX_W-1:0]   raddr;
   logic               wen;
   logic [IDX_W-1:0]   waddr;
   logic [IDX_W:0]     wdata;
   logic [IDX_W:0]     head_entry;

   // least level whose size covers the request, capped at the top
   always_comb begin
      need = '0;
      for (int i = 0; i < TOP; i++) begin
         if ((UNITS_W'(1) << i) < units_ff) begin
            need = LVL_W'(i + 1);
         end
      end
   end

   always_comb begin
      first = '0;
      found = 1'b0;
      for (int i = TOP; i >= 0; i--) begin
         if (head_vld_ff[i] && (LVL_W'(i) >= need)) begin
            first = LVL_W'(i);
            found = 1'b1;
         end
      end
   end

   assign bit_lv     = IDX_W'(1) << lv_ff;
   assign buddy      = addr_ff ^ bit_lv;
   assign merged     = buddy & ~bit_lv;
   assign nxt        = rdata_ff[IDX_W-1:0];
   assign half_blk   = addr_ff + bit_lv;
   assign head_entry = {head_vld_ff[lv_ff], head_idx_ff[lv_ff]};

   assign status.is_free       = (opc_ff == OP_FREE);
   assign status.alloc_fail    = (units_ff > UNITS_W'(HEAP_UNITS)) || !found;
   assign status.lv_gt_need    = (lv_ff > need_ff);
   assign status.at_top        = (lv_ff == LVL_W'(TOP));
   assign status.head_vld_lv   = head_vld_ff[lv_ff];
   assign status.head_is_buddy = (head_idx_ff[lv_ff] == buddy);
   assign status.link_vld      = rdata_ff[IDX_W];
   assign status.nxt_is_buddy  = (nxt == buddy);
   assign status.walk_limit    = (cnt_ff == CNT_W'(HEAP_UNITS));

   always_comb begin
      raddr = nxt;
      wen   = 1'b0;
      waddr = addr_ff;
      wdata = head_entry;
      case (cmd)
         CMD_ALLOC_POP, CMD_WALK_START: raddr = head_idx_ff[lv_ff];
         CMD_BUDDY_READ:                raddr = buddy;
         CMD_SPLIT_PUSH: begin
            wen   = 1'b1;
            waddr = half_blk;
         end
         CMD_PUSH: begin
            wen = 1'b1;
         end
         CMD_UNLINK: begin
            wen   = 1'b1;
            waddr = cur_ff;
            wdata = rdata_ff;
         end
         default: begin
            raddr = nxt;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // block 0 starts alone on the top list: end its chain
         link_mem[IDX_W'(0)] <= '0;
      end else if (wen) begin
         link_mem[waddr] <= wdata;
      end
      rdata_ff <= link_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_vld_ff <= LEVELS'(1) << TOP;
         for (int i = 0; i < LEVELS; i++) begin
            head_idx_ff[i] <= '0;
         end
      end else begin
         case (cmd)
            CMD_POP_HEAD, CMD_BPOP: begin
               head_idx_ff[lv_ff] <= rdata_ff[IDX_W-1:0];
               head_vld_ff[lv_ff] <= rdata_ff[IDX_W];
            end
            CMD_SPLIT_PUSH: begin
               head_idx_ff[lv_ff] <= half_blk;
               head_vld_ff[lv_ff] <= 1'b1;
            end
            CMD_PUSH: begin
               head_idx_ff[lv_ff] <= addr_ff;
               head_vld_ff[lv_ff] <= 1'b1;
            end
            default: begin
               head_vld_ff <= head_vld_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd)
         CMD_LOAD: begin
            opc_ff   <= req_opcode;
            units_ff <= req_units;
            addr_ff  <= req_index;
            lv_ff    <= (req_level > LVL_W'(TOP)) ? LVL_W'(TOP) : req_level;
         end
         CMD_ALLOC_SEL: begin
            lv_ff   <= first;
            need_ff <= need;
         end
         CMD_ALLOC_POP: addr_ff <= head_idx_ff[lv_ff];
         CMD_SPLIT_DEC: lv_ff <= lv_ff - LVL_W'(1);
         CMD_ALLOC_DONE: begin
            ok_ff      <= 1'b1;
            res_idx_ff <= addr_ff;
            res_lv_ff  <= need_ff;
         end
         CMD_FAIL: begin
            ok_ff      <= 1'b0;
            res_idx_ff <= '0;
            res_lv_ff  <= '0;
         end
         CMD_PUSH: begin
            ok_ff      <= 1'b1;
            res_idx_ff <= addr_ff;
            res_lv_ff  <= lv_ff;
         end
         CMD_BPOP, CMD_UNLINK: begin
            addr_ff <= merged;
            lv_ff   <= lv_ff + LVL_W'(1);
         end
         CMD_WALK_START: begin
            cur_ff <= head_idx_ff[lv_ff];
            cnt_ff <= '0;
         end
         CMD_WALK_STEP: begin
            cur_ff <= nxt;
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
         default: begin
            cur_ff <= cur_ff;
         end
      endcase
   end

   assign rsp_ok    = ok_ff;
   assign rsp_index = res_idx_ff;
   assign rsp_level = res_lv_ff;

   a_split_above_need: assert property (@(posedge clock) disable iff (reset)
      (cmd == CMD_SPLIT_PUSH) |-> (lv_ff >= need_ff))
      else $error("split pushed below the requested level");

   a_walk_bounded: assert property (@(posedge clock) disable iff (reset)
      (cmd == CMD_WALK_STEP) |=> (cnt_ff <= CNT_W'(HEAP_UNITS)))
      else $error("list walk overran its visit budget");

   a_merge_climbs: assert property (@(posedge clock) disable iff (reset)
      (cmd == CMD_BPOP || cmd == CMD_UNLINK) |=> (lv_ff == $past(lv_ff) + LVL_W'(1)))
      else $error("merge did not move one level up");

endmodule

// ===== rtl/buddy_block_allocator.sv =====
`timescale 1ns / 1ps
// Allocate: pick the lowest nonempty list that fits, pop its head, then split down to the needed level.
// Free: merge with the buddy while it is free (head hit or found by a list walk), then push;
// the walk visits entries through the registered read of the link memory, bounded by the heap size.
// One request at a time; the next beat is taken once the result beat is taken.
// Synchronous reset: the top level holds block 0, all other lists empty.
module buddy_block_allocator
   import bba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // request_units[10:0], block_index[20:11], block_level_in[24:21]
   input  logic        req_tuser,  // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata   // ok[0], result_index[10:1], result_level[14:11]
);

   cmd_type            cmd;
   status_type         status;
   logic               rsp_ok;
   logic [IDX_W-1:0]   rsp_index;
   logic [LVL_W-1:0]   rsp_level;

   bba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_fire   (req_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid)
   );

   bba_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_opcode (req_tuser),
      .req_units  (req_tdata[10:0]),
      .req_index  (req_tdata[20:11]),
      .req_level  (req_tdata[24:21]),
      .status     (status),
      .rsp_ok     (rsp_ok),
      .rsp_index  (rsp_index),
      .rsp_level  (rsp_level)
   );

   assign rsp_tdata = {1'b0, rsp_level, rsp_index, rsp_ok};

endmodule

// ===== sim/bba_checker.sv =====
`timescale 1ns / 1ps
module bba_checker
   import bba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   output int          fail_count,
   output int          pending
);

   // laid out as on rsp_tdata: ok lowest, then index, then level
   typedef struct packed {
      logic [LVL_W-1:0] level;
      logic [IDX_W-1:0] index;
      logic             ok;
   } grant_type;

   logic [IDX_W-1:0] head_at [LEVELS];
   logic             head_ok [LEVELS];
   logic [IDX_W-1:0] link_to [HEAP_UNITS];
   logic             link_ok [HEAP_UNITS];
   grant_type        grants_due [$];
   int               mismatches;

   assign pending = grants_due.size();

   function automatic void push_free(logic [IDX_W-1:0] blk, int lv);
      link_to[blk] = head_at[lv];
      link_ok[blk] = head_ok[lv];
      head_at[lv]  = blk;
      head_ok[lv]  = 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] pop_free(int lv);
      logic [IDX_W-1:0] blk;
      blk = head_at[lv];
      head_at[lv] = link_to[blk];
      head_ok[lv] = link_ok[blk];
      return blk;
   endfunction

   function automatic bit unlink_free(logic [IDX_W-1:0] blk, int lv);
      logic [IDX_W-1:0] cur, nxt;
      if (!head_ok[lv]) return 0;
      if (head_at[lv] == blk) begin
         void'(pop_free(lv));
         return 1;
      end
      cur = head_at[lv];
      for (int n = 0; n < HEAP_UNITS; n++) begin
         if (!link_ok[cur]) return 0;
         nxt = link_to[cur];
         if (nxt == blk) begin
            link_to[cur] = link_to[nxt];
            link_ok[cur] = link_ok[nxt];
            return 1;
         end
         cur = nxt;
      end
      return 0;
   endfunction

   function automatic grant_type serve(logic op, logic [31:0] d);
      grant_type        g;
      logic [10:0]      units;
      logic [IDX_W-1:0] addr, bit_m, blk;
      int               need, lv;
      g = '0;
      if (op == OP_ALLOC) begin
         units = d[10:0];
         if (units <= HEAP_UNITS) begin
            need = 0;
            while (need < TOP && (1 << need) < units) need++;
            lv = need;
            while (lv < LEVELS && !head_ok[lv]) lv++;
            if (lv < LEVELS) begin
               blk = pop_free(lv);
               for (int i = lv; i > need; i--)
                  push_free(blk + (IDX_W'(1) << (i - 1)), i - 1);
               g.ok = 1'b1;
               g.index = blk;
               g.level = LVL_W'(need);
            end
         end
      end else begin
         addr = d[20:11];
         lv = d[24:21];
         if (lv > TOP) lv = TOP;
         while (lv < TOP) begin
            bit_m = IDX_W'(1) << lv;
            if (!unlink_free(addr ^ bit_m, lv)) break;
            addr = addr & ~bit_m;
            lv++;
         end
         push_free(addr, lv);
         g.ok = 1'b1;
         g.index = addr;
         g.level = LVL_W'(lv);
      end
      return g;
   endfunction

   always @(posedge clock) begin
      grant_type exp_g, got;
      if (reset) begin
         for (int i = 0; i < LEVELS; i++) begin
            head_at[i] <= '0;
            head_ok[i] <= (i == TOP);
         end
         for (int i = 0; i < HEAP_UNITS; i++) begin
            link_to[i] = '0;
            link_ok[i] = 1'b0;
         end
         grants_due.delete();
         fail_count <= 0;
         mismatches <= 0;
      end else begin
         if (req_tvalid && req_tready) grants_due.push_back(serve(req_tuser, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[14:0];
            if (grants_due.size() == 0) begin
               fail_count <= fail_count + 1;
               mismatches <= mismatches + 1;
               if (mismatches < 10) $display("unexpected result beat %h", got);
            end else begin
               exp_g = grants_due.pop_front();
               if (got !== exp_g) begin
                  fail_count <= fail_count + 1;
                  mismatches <= mismatches + 1;
                  if (mismatches < 10)
                     $display("result mismatch: exp ok=%0b idx=%0d lvl=%0d got ok=%0b idx=%0d lvl=%0d",
                              exp_g.ok, exp_g.index, exp_g.level, got.ok, got.index, got.level);
               end
            end
         end
      end
   end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
   import bba_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tuser = OP_ALLOC;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   int          fail_count, pending;
   int          send_idle = 0, recv_idle = 0;
   bit          hold_recv = 0, stim_done = 0;
   int          quiet = 0;

   // allocations held, for freeing later
   logic [IDX_W-1:0] held_idx [$];
   logic [LVL_W-1:0] held_lvl [$];

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   buddy_block_allocator u_dut (.*);

   bba_checker u_chk (.*);

   // track granted blocks so that most frees are well formed
   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready && rsp_tdata[0] && $urandom_range(9) != 0) begin
         held_idx.push_back(rsp_tdata[10:1]);
         held_lvl.push_back(rsp_tdata[14:11]);
      end

   always @(negedge clock)
      rsp_tready <= !reset && !hold_recv && ($urandom_range(99) >= recv_idle);

   // valid stays up after a beat unless the sender idles; the caller drops it at the end
   task automatic send_beat(logic op, logic [10:0] units, logic [9:0] idx, logic [3:0] lvl);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tuser  <= op;
      req_tdata  <= {7'd0, lvl, idx, units};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_alloc(logic [10:0] u);
      send_beat(OP_ALLOC, u, 10'($urandom), 4'($urandom));
   endtask

   task automatic send_free_any();
      int k;
      if (held_idx.size() > 0 && $urandom_range(9) != 0) begin
         k = $urandom_range(held_idx.size() - 1);
         send_beat(OP_FREE, 11'($urandom), held_idx[k], held_lvl[k]);
         held_idx.delete(k);
         held_lvl.delete(k);
      end else
         send_beat(OP_FREE, 11'($urandom), 10'($urandom), 4'($urandom));
   endtask

   task automatic random_part(int n);
      int u;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(1)) begin
            case ($urandom_range(9))
               0: u = $urandom_range(2047);
               1: u = $urandom_range(1024, 513);
               default: u = $urandom_range(1 << $urandom_range(6));
            endcase
            send_alloc(11'(u));
         end else
            send_free_any();
      end
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      send_idle = 34; recv_idle = 46;
      // directed: extremes, zero and oversize requests, odd frees
      send_alloc(11'd0);
      send_alloc(11'd1);
      send_alloc(11'd3);
      send_alloc(11'd1024);
      send_alloc(11'd1025);
      send_alloc(11'd2047);
      send_alloc(11'd512);
      send_beat(OP_FREE, '0, 10'd0, 4'd0);
      send_beat(OP_FREE, '0, 10'd1, 4'd0);
      send_beat(OP_FREE, '0, 10'd4, 4'd2);
      send_beat(OP_FREE, '0, 10'd1023, 4'd15);
      send_beat(OP_FREE, '0, 10'd0, 4'd10);
      send_beat(OP_FREE, '0, 10'd5, 4'd1);
      send_beat(OP_FREE, '0, 10'd5, 4'd1);
      send_beat(OP_FREE, '0, 10'd512, 4'd9);
      send_alloc(11'd1024);
      send_alloc(11'd700);
      random_part(230);
      send_idle = 46; recv_idle = 34;
      random_part(230);
      // long receiver hold-off while requests keep coming
      fork
         begin
            hold_recv = 1;
            repeat (300) @(negedge clock);
            hold_recv = 0;
         end
         random_part(10);
      join
      send_idle = 0; recv_idle = 0;
      random_part(260);
      req_tvalid <= 1'b0;
      stim_done = 1;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet > 50000) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      wait (stim_done);
      while (pending != 0) @(posedge clock);
      repeat (1100) @(posedge clock);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
